/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/lss_pkg.sv */
`timescale 1ns / 1ps

package lss_pkg;

    localparam int NUM_STYLES       = 64;
    localparam int PATTERN_CAPACITY = 64;

    localparam int STYLE_FIELD_W = 6;
    localparam int CHAR_W        = 8;
    localparam int TIME_W        = 31;
    localparam int LEVEL_W       = 13;
    localparam int MODE_W        = 2;

    localparam int STYLE_W   = (NUM_STYLES > 1) ? $clog2(NUM_STYLES) : 1;
    localparam int LEN_W     = $clog2(PATTERN_CAPACITY);
    localparam int SUM_W     = LEN_W + 10;
    localparam int PAT_DEPTH = NUM_STYLES * PATTERN_CAPACITY;
    localparam int PAT_AW    = $clog2(PAT_DEPTH);

    localparam int DIV_W      = 32;
    localparam int STEP_BITS  = 4;
    localparam int DIV_STEPS  = DIV_W / STEP_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CHAR_W-1:0] CHAR_BASE   = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_NORMAL = 8'd109;
    localparam int LEVEL_SCALE = 22;
    localparam int LEVEL_EMPTY = 256;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [MODE_W-1:0] FLAT_ANIMATE = 2'd0;
    localparam logic [MODE_W-1:0] FLAT_AVERAGE = 2'd1;
    localparam logic [MODE_W-1:0] FLAT_PEAK    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_TICK_RD,
        ST_TICK_START,
        ST_TICK_DIV,
        ST_TICK_CHAR,
        ST_TICK_EMIT
    } lss_state_t;

    typedef struct packed {
        logic load;
        logic avg_start;
        logic avg_write;
        logic tick_start;
        logic div_start_tick;
        logic emit;
    } lss_cmd_t;

    typedef struct packed {
        logic term_div;
        logic div_done;
        logic out_free;
        logic last_style;
    } lss_status_t;

    function automatic logic [PAT_AW-1:0] pat_addr(input logic [STYLE_W-1:0] style,
                                                   input logic [LEN_W-1:0] pos);
        return PAT_AW'(PAT_AW'(style) * PAT_AW'(PATTERN_CAPACITY) + PAT_AW'(pos));
    endfunction

endpackage

/* rtl/lss_in_if.sv */
`timescale 1ns / 1ps

interface lss_in_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [lss_pkg::STYLE_FIELD_W-1:0]  style_index;
    logic [lss_pkg::CHAR_W-1:0]         char_code;
    logic [lss_pkg::TIME_W-1:0]         time_tenths;

    modport source (output valid, func, style_index, char_code, time_tenths, input ready);
    modport sink   (input valid, func, style_index, char_code, time_tenths, output ready);
endinterface

/* rtl/lss_out_if.sv */
`timescale 1ns / 1ps

interface lss_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [lss_pkg::STYLE_FIELD_W-1:0]      out_style_index;
    logic signed [lss_pkg::LEVEL_W-1:0]     level;
    logic                                   last_style;

    modport source (output valid, out_style_index, level, last_style, input ready);
    modport sink   (input valid, out_style_index, level, last_style, output ready);
endinterface

/* rtl/lss_div.sv */
`timescale 1ns / 1ps

module lss_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lss_pkg::DIV_W-1:0]    dividend,
    input  logic [lss_pkg::LEN_W-1:0]    divisor,
    output logic                         done,
    output logic [lss_pkg::DIV_W-1:0]    quotient,
    output logic [lss_pkg::LEN_W-1:0]    remainder
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [lss_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [lss_pkg::DIV_W-1:0]      quo_reg;
    logic [lss_pkg::DIV_W-1:0]      quo_next;
    logic [lss_pkg::LEN_W-1:0]      rem_reg;
    logic [lss_pkg::LEN_W-1:0]      rem_next;
    logic [lss_pkg::LEN_W-1:0]      div_reg;
    logic [lss_pkg::LEN_W:0]        trial;

    // Restoring division, several quotient bits per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < lss_pkg::STEP_BITS; i++)
        begin
            trial    = {rem_next, quo_next[lss_pkg::DIV_W-1]};
            quo_next = {quo_next[lss_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next    = lss_pkg::LEN_W'(trial - {1'b0, div_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = lss_pkg::LEN_W'(trial);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == lss_pkg::DIV_CNT_W'(lss_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/lss_datapath.sv */
`timescale 1ns / 1ps

module lss_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lss_pkg::lss_cmd_t                       cmd,
    output lss_pkg::lss_status_t                    status,
    input  logic [lss_pkg::STYLE_FIELD_W-1:0]       style_index,
    input  logic [lss_pkg::CHAR_W-1:0]              char_code,
    input  logic [lss_pkg::TIME_W-1:0]              time_tenths,
    input  logic                                    cfg_we,
    input  logic [lss_pkg::MODE_W-1:0]              cfg_wdata,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [lss_pkg::STYLE_FIELD_W-1:0]       out_style_index,
    output logic signed [lss_pkg::LEVEL_W-1:0]      out_level,
    output logic                                    out_last
);

    localparam logic signed [lss_pkg::LEVEL_W-1:0] SCALE_S = lss_pkg::LEVEL_W'(lss_pkg::LEVEL_SCALE);

    // storage
    logic [lss_pkg::CHAR_W-1:0]     pat_mem  [lss_pkg::PAT_DEPTH];
    logic [lss_pkg::LEN_W-1:0]      len_mem  [lss_pkg::NUM_STYLES];
    logic [lss_pkg::CHAR_W-1:0]     peak_mem [lss_pkg::NUM_STYLES];
    logic [lss_pkg::CHAR_W-1:0]     avg_mem  [lss_pkg::NUM_STYLES];
    logic [lss_pkg::NUM_STYLES-1:0] len_valid_reg;

    logic [lss_pkg::CHAR_W-1:0]     pat_rd_reg;
    logic [lss_pkg::LEN_W-1:0]      len_rd_reg;
    logic                           len_hit_reg;
    logic [lss_pkg::CHAR_W-1:0]     peak_rd_reg;
    logic [lss_pkg::CHAR_W-1:0]     avg_rd_reg;

    // load state
    logic [lss_pkg::LEN_W-1:0]          load_pos_reg;
    logic signed [lss_pkg::SUM_W-1:0]   load_sum_reg;
    logic [lss_pkg::CHAR_W-1:0]         load_peak_reg;
    logic [lss_pkg::STYLE_FIELD_W-1:0]  load_style_reg;
    logic                               neg_reg;

    // tick state
    logic [lss_pkg::MODE_W-1:0]     flat_mode_reg;
    logic [lss_pkg::TIME_W-1:0]     time_reg;
    logic [lss_pkg::STYLE_W-1:0]    style_reg;

    // output register
    logic                                   out_valid_reg;
    logic [lss_pkg::STYLE_FIELD_W-1:0]      out_style_reg;
    logic signed [lss_pkg::LEVEL_W-1:0]     out_level_reg;
    logic                                   out_last_reg;

    logic [lss_pkg::STYLE_FIELD_W-1:0]  eff_style;
    logic [lss_pkg::STYLE_W-1:0]        eff_idx;
    logic                               eff_valid;
    logic                               is_term;
    logic                               pos_full;
    logic signed [8:0]                  load_diff;
    logic [lss_pkg::SUM_W-1:0]          sum_mag;
    logic [lss_pkg::SUM_W-1:0]          avg_wide;
    logic [lss_pkg::CHAR_W-1:0]         avg_char;

    logic                           div_start;
    logic [lss_pkg::DIV_W-1:0]      div_dividend;
    logic [lss_pkg::LEN_W-1:0]      div_divisor;
    logic                           div_done;
    logic [lss_pkg::DIV_W-1:0]      div_quo;
    logic [lss_pkg::LEN_W-1:0]      div_rem;

    logic [lss_pkg::PAT_AW-1:0]             pat_raddr;
    logic [lss_pkg::PAT_AW-1:0]             pat_waddr;
    logic [lss_pkg::LEN_W-1:0]              cur_len;
    logic [lss_pkg::CHAR_W-1:0]             sel_char;
    logic signed [8:0]                      char_diff;
    logic signed [lss_pkg::LEVEL_W-1:0]     diff_ext;
    logic signed [lss_pkg::LEVEL_W-1:0]     level_calc;
    logic                                   last_style;

    // load path
    assign eff_style = (load_pos_reg == '0) ? style_index : load_style_reg;
    assign eff_idx   = lss_pkg::STYLE_W'(eff_style);
    assign eff_valid = 32'(eff_style) < lss_pkg::NUM_STYLES;
    assign is_term   = (char_code == '0);
    assign pos_full  = 32'(load_pos_reg) >= lss_pkg::PATTERN_CAPACITY - 1;
    assign load_diff = $signed({1'b0, char_code}) - $signed({1'b0, lss_pkg::CHAR_BASE});
    assign pat_waddr = lss_pkg::pat_addr(eff_idx, load_pos_reg);

    assign sum_mag  = load_sum_reg[lss_pkg::SUM_W-1] ? lss_pkg::SUM_W'(-load_sum_reg)
                                                     : lss_pkg::SUM_W'(load_sum_reg);
    assign avg_wide = neg_reg ? lss_pkg::SUM_W'(lss_pkg::SUM_W'(lss_pkg::CHAR_BASE)
                                                - div_quo[lss_pkg::SUM_W-1:0])
                              : lss_pkg::SUM_W'(lss_pkg::SUM_W'(lss_pkg::CHAR_BASE)
                                                + div_quo[lss_pkg::SUM_W-1:0]);
    assign avg_char = avg_wide[lss_pkg::CHAR_W-1:0];

    // divider operands
    assign div_start    = cmd.avg_start | cmd.div_start_tick;
    assign div_dividend = cmd.avg_start ? lss_pkg::DIV_W'(sum_mag) : lss_pkg::DIV_W'(time_reg);
    assign div_divisor  = cmd.avg_start ? load_pos_reg : cur_len;

    lss_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // tick path
    assign cur_len    = len_hit_reg ? len_rd_reg : '0;
    assign pat_raddr  = lss_pkg::pat_addr(style_reg, div_rem);
    assign last_style = (style_reg == lss_pkg::STYLE_W'(lss_pkg::NUM_STYLES - 1));

    always_comb
    begin
        case (flat_mode_reg)
            lss_pkg::FLAT_PEAK:    sel_char = peak_rd_reg;
            lss_pkg::FLAT_AVERAGE: sel_char = avg_rd_reg;
            default:               sel_char = pat_rd_reg;
        endcase
        char_diff = $signed({1'b0, sel_char}) - $signed({1'b0, lss_pkg::CHAR_BASE});
        diff_ext  = lss_pkg::LEVEL_W'(char_diff);
        if (cur_len == '0)
        begin
            level_calc = lss_pkg::LEVEL_W'(lss_pkg::LEVEL_EMPTY);
        end
        else
        begin
            level_calc = diff_ext * SCALE_S;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && !is_term && !pos_full && eff_valid)
        begin
            pat_mem[pat_waddr] <= char_code;
        end
        pat_rd_reg <= pat_mem[pat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && is_term && eff_valid)
        begin
            len_mem[eff_idx]  <= load_pos_reg;
            peak_mem[eff_idx] <= (load_pos_reg == '0) ? lss_pkg::CHAR_NORMAL : load_peak_reg;
        end
        len_rd_reg  <= len_mem[style_reg];
        peak_rd_reg <= peak_mem[style_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && is_term && eff_valid && (load_pos_reg == '0))
        begin
            avg_mem[eff_idx] <= lss_pkg::CHAR_NORMAL;
        end
        else if (cmd.avg_write)
        begin
            avg_mem[lss_pkg::STYLE_W'(load_style_reg)] <= avg_char;
        end
        avg_rd_reg <= avg_mem[style_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg  <= '0;
            len_hit_reg    <= 1'b0;
            load_pos_reg   <= '0;
            load_sum_reg   <= '0;
            load_peak_reg  <= lss_pkg::CHAR_BASE;
            load_style_reg <= '0;
            flat_mode_reg  <= lss_pkg::FLAT_ANIMATE;
            style_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            len_hit_reg <= len_valid_reg[style_reg];

            if (cfg_we)
            begin
                flat_mode_reg <= cfg_wdata;
            end

            if (cmd.load)
            begin
                load_style_reg <= eff_style;
                if (is_term)
                begin
                    if (eff_valid)
                    begin
                        len_valid_reg[eff_idx] <= 1'b1;
                    end
                    load_pos_reg  <= '0;
                    load_sum_reg  <= '0;
                    load_peak_reg <= lss_pkg::CHAR_BASE;
                end
                else if (!pos_full)
                begin
                    load_pos_reg <= load_pos_reg + 1'b1;
                    load_sum_reg <= load_sum_reg + lss_pkg::SUM_W'(load_diff);
                    if (char_code > load_peak_reg)
                    begin
                        load_peak_reg <= char_code;
                    end
                end
            end

            if (cmd.tick_start)
            begin
                style_reg <= '0;
            end
            else if (cmd.emit)
            begin
                style_reg <= last_style ? '0 : style_reg + 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.avg_start)
        begin
            neg_reg <= load_sum_reg[lss_pkg::SUM_W-1];
        end
        if (cmd.tick_start)
        begin
            time_reg <= time_tenths;
        end
        if (cmd.emit)
        begin
            out_style_reg <= lss_pkg::STYLE_FIELD_W'(style_reg);
            out_level_reg <= level_calc;
            out_last_reg  <= last_style;
        end
    end

    assign status.term_div   = is_term && eff_valid && (load_pos_reg != '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.last_style = last_style;

    assign out_valid       = out_valid_reg;
    assign out_style_index = out_style_reg;
    assign out_level       = out_level_reg;
    assign out_last        = out_last_reg;

endmodule

/* rtl/lss_ctrl.sv */
`timescale 1ns / 1ps

module lss_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_func,
    output logic                    item_ready,
    output lss_pkg::lss_cmd_t       cmd,
    input  lss_pkg::lss_status_t    status
);

    lss_pkg::lss_state_t state_reg;
    lss_pkg::lss_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            lss_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_func == lss_pkg::FUNC_TICK)
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = lss_pkg::ST_TICK_RD;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (status.term_div)
                        begin
                            cmd.avg_start = 1'b1;
                            state_next    = lss_pkg::ST_AVG;
                        end
                    end
                end
            end
            lss_pkg::ST_AVG:
            begin
                if (status.div_done)
                begin
                    cmd.avg_write = 1'b1;
                    state_next    = lss_pkg::ST_IDLE;
                end
            end
            lss_pkg::ST_TICK_RD:
            begin
                state_next = lss_pkg::ST_TICK_START;
            end
            lss_pkg::ST_TICK_START:
            begin
                cmd.div_start_tick = 1'b1;
                state_next         = lss_pkg::ST_TICK_DIV;
            end
            lss_pkg::ST_TICK_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = lss_pkg::ST_TICK_CHAR;
                end
            end
            lss_pkg::ST_TICK_CHAR:
            begin
                state_next = lss_pkg::ST_TICK_EMIT;
            end
            lss_pkg::ST_TICK_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_style ? lss_pkg::ST_IDLE : lss_pkg::ST_TICK_RD;
                end
            end
            default:
            begin
                state_next = lss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/light_style_sequencer.sv */
`timescale 1ns / 1ps

// Light style sequencer. Load requests (func 0) append one character to a style's
// pattern while it has room; a zero character closes the string, and when the string is
// not empty the average character is found by the shared divider, which retires four
// quotient bits a cycle. A tick request (func 1) emits one level per style in style
// order; for each style it reads the pattern length, starts the divider for time mod
// length, waits on it, reads the character and emits when the output is free. No
// request is taken while a tick or an average is in progress. flat_mode selects
// animated, average or peak levels.
`include "assert_macros.svh"

module light_style_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    lss_in_if.sink                      item,
    lss_out_if.source                   result,
    input  logic                        cfg_we,
    input  logic [lss_pkg::MODE_W-1:0]  cfg_wdata
);

    lss_pkg::lss_cmd_t      cmd;
    lss_pkg::lss_status_t   status;

    lss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item.func),
        .item_ready (item.ready),
        .cmd        (cmd),
        .status     (status)
    );

    lss_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .style_index     (item.style_index),
        .char_code       (item.char_code),
        .time_tenths     (item.time_tenths),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_style_index (result.out_style_index),
        .out_level       (result.level),
        .out_last        (result.last_style)
    );

    `ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, status.out_free, "pending result overwritten")
    `ASSERT_NEXT(a_last_idle, clk, rst_n, cmd.emit && status.last_style, item.ready,
                 "not idle after last style")
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, cmd.tick_start, !item.ready, "request taken during tick")
    `ASSERT_IMPL(a_div_restart, clk, rst_n, status.div_done,
                 !cmd.avg_start && !cmd.div_start_tick, "divider restarted while busy")

endmodule

/* dv/light_style_sequencer_tb.sv */
`timescale 1ns / 1ps

module light_style_sequencer_tb;
    import lss_pkg::*;

    localparam int LIMIT_CYCLES   = 2000000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 6;
    localparam int PHASE_REQUESTS = 8;
    localparam int DIR_ROWS       = 16;

    localparam logic [MODE_W-1:0] FLAT_ANIMATE_ALT = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX         = 31'h7fff_ffff;

    typedef struct packed {
        logic                       func;
        logic [STYLE_FIELD_W-1:0]   style;
        logic [CHAR_W-1:0]          ch;
        logic [TIME_W-1:0]          tenths;
    } light_req_t;

    typedef struct packed {
        light_req_t                 req;
        logic                       typed;
        logic [STYLE_FIELD_W-1:0]   typed_style;
        logic signed [LEVEL_W-1:0]  typed_level;
    } dir_row_t;

    typedef struct packed {
        logic [STYLE_FIELD_W-1:0]   style;
        logic signed [LEVEL_W-1:0]  level;
        logic                       last;
    } level_report_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [MODE_W-1:0] cfg_wdata;

    lss_in_if  item_bus ();
    lss_out_if level_bus ();

    light_style_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (level_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [CHAR_W-1:0]  style_chars [NUM_STYLES][PATTERN_CAPACITY];
    int unsigned        style_len   [NUM_STYLES];
    logic [CHAR_W-1:0]  style_peak  [NUM_STYLES];
    logic [CHAR_W-1:0]  style_avg   [NUM_STYLES];
    int unsigned        ld_pos;
    int                 ld_sum;
    int unsigned        ld_peak;
    int unsigned        ld_style;
    logic [MODE_W-1:0]  flat_mode_shadow;

    level_report_t expected_levels [$];

    int  requests_sent = 0;
    int  error_count   = 0;
    int  cycle_count   = 0;
    int  sink_wait     = 0;
    bit  src_idle_on   = 1'b1;
    bit  snk_idle_on   = 1'b1;
    bit  hold_go       = 1'b0;
    logic hold_off     = 1'b0;
    level_report_t sink_want;

    logic [MODE_W-1:0] phase_modes [PHASES] = '{
        FLAT_PEAK, FLAT_AVERAGE, FLAT_ANIMATE_ALT, FLAT_ANIMATE, FLAT_AVERAGE, FLAT_PEAK
    };

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{FUNC_TICK, 6'd0,  8'd0,   31'd0},           1'b1, 6'd0, 13'sd256},
        '{'{FUNC_LOAD, 6'd0,  8'd97,  31'd0},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_LOAD, 6'd45, 8'd255, TIME_MAX},        1'b0, 6'd0, 13'sd0},
        '{'{FUNC_LOAD, 6'd21, 8'd0,   31'd0},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_TICK, 6'd0,  8'd0,   31'd1},           1'b1, 6'd0, 13'sd3476},
        '{'{FUNC_TICK, 6'd63, 8'd255, 31'd0},           1'b1, 6'd0, 13'sd0},
        '{'{FUNC_TICK, 6'd0,  8'd0,   TIME_MAX},        1'b0, 6'd0, 13'sd0},
        '{'{FUNC_LOAD, 6'd63, 8'd1,   31'd0},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_TICK, 6'd63, 8'd255, 31'd3},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_LOAD, 6'd0,  8'd128, 31'd0},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_LOAD, 6'd0,  8'd0,   31'd0},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_TICK, 6'd0,  8'd0,   31'h5555_5555},   1'b0, 6'd0, 13'sd0},
        '{'{FUNC_TICK, 6'd42, 8'd170, 31'h2aaa_aaaa},   1'b0, 6'd0, 13'sd0},
        '{'{FUNC_LOAD, 6'd42, 8'd0,   31'd0},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_LOAD, 6'd0,  8'd0,   31'd0},           1'b0, 6'd0, 13'sd0},
        '{'{FUNC_TICK, 6'd0,  8'd0,   31'd5},           1'b0, 6'd0, 13'sd0}
    };

    always #2 clk = ~clk;

    task automatic model_request(input light_req_t req, input bit typed,
                                 input logic [STYLE_FIELD_W-1:0] typed_style,
                                 input logic signed [LEVEL_W-1:0] typed_level);
        level_report_t rep;
        int unsigned   c;
        int            lv;
        int            avg;
        if (req.func == FUNC_LOAD)
        begin
            if (ld_pos == 0)
                ld_style = req.style;
            if (req.ch == 0)
            begin
                style_len[ld_style] = ld_pos;
                if (ld_pos != 0)
                begin
                    avg = ld_sum / int'(ld_pos) + int'(CHAR_BASE);
                    style_peak[ld_style] = ld_peak[CHAR_W-1:0];
                    style_avg[ld_style]  = avg[CHAR_W-1:0];
                end
                else
                begin
                    style_peak[ld_style] = CHAR_NORMAL;
                    style_avg[ld_style]  = CHAR_NORMAL;
                end
                ld_pos  = 0;
                ld_sum  = 0;
                ld_peak = CHAR_BASE;
            end
            else if (ld_pos < PATTERN_CAPACITY - 1)
            begin
                style_chars[ld_style][ld_pos] = req.ch;
                ld_sum = ld_sum + int'(req.ch) - int'(CHAR_BASE);
                if (req.ch > ld_peak)
                    ld_peak = req.ch;
                ld_pos++;
            end
        end
        else
        begin
            for (int j = 0; j < NUM_STYLES; j++)
            begin
                if (style_len[j] == 0)
                    lv = LEVEL_EMPTY;
                else
                begin
                    if (flat_mode_shadow == FLAT_PEAK)
                        c = style_peak[j];
                    else if (flat_mode_shadow == FLAT_AVERAGE)
                        c = style_avg[j];
                    else
                        c = style_chars[j][int'(req.tenths) % style_len[j]];
                    lv = (int'(c) - int'(CHAR_BASE)) * LEVEL_SCALE;
                end
                if (typed)
                    lv = (j == typed_style) ? int'(typed_level) : LEVEL_EMPTY;
                rep.style = j[STYLE_FIELD_W-1:0];
                rep.level = lv[LEVEL_W-1:0];
                rep.last  = (j == NUM_STYLES - 1);
                expected_levels.push_back(rep);
            end
        end
    endtask

    task automatic send_request(input light_req_t req, input bit typed,
                                input logic [STYLE_FIELD_W-1:0] typed_style,
                                input logic signed [LEVEL_W-1:0] typed_level);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.func        <= req.func;
        item_bus.style_index <= req.style;
        item_bus.char_code   <= req.ch;
        item_bus.time_tenths <= req.tenths;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        model_request(req, typed, typed_style, typed_level);
        requests_sent++;
    endtask

    function automatic light_req_t rand_tick();
        light_req_t req;
        req.func   = FUNC_TICK;
        req.style  = STYLE_FIELD_W'($urandom);
        req.ch     = CHAR_W'($urandom);
        req.tenths = ($urandom_range(0, 2) == 0) ? TIME_W'($urandom)
                                                 : TIME_W'($urandom_range(0, 200));
        return req;
    endfunction

    task automatic send_tick();
        send_request(rand_tick(), 1'b0, '0, '0);
    endtask

    task automatic send_string(input logic [STYLE_FIELD_W-1:0] style, input int len,
                               input bit terminate);
        light_req_t req;
        req.func = FUNC_LOAD;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_tick();
            req.style  = (k == 0 || $urandom_range(0, 1) == 0) ? style
                                                              : STYLE_FIELD_W'($urandom);
            req.ch     = ($urandom_range(0, 1) == 0) ? CHAR_W'($urandom_range(97, 122))
                                                     : CHAR_W'($urandom_range(1, 255));
            req.tenths = TIME_W'($urandom);
            send_request(req, 1'b0, '0, '0);
        end
        if (terminate)
        begin
            req.style  = (len == 0) ? style : STYLE_FIELD_W'($urandom);
            req.ch     = '0;
            req.tenths = TIME_W'($urandom);
            send_request(req, 1'b0, '0, '0);
        end
    endtask

    task automatic run_phase(input int quota, input bit overlong);
        int first;
        int pick;
        int len;
        first = requests_sent;
        if (overlong)
            send_string(STYLE_FIELD_W'($urandom), PATTERN_CAPACITY + 1, 1'b1);
        while (requests_sent - first < quota)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                send_tick();
            else
            begin
                len = (pick == 1) ? 0 : (pick == 5) ? $urandom_range(7, 20)
                                                    : $urandom_range(1, 6);
                send_string(STYLE_FIELD_W'($urandom), len, $urandom_range(0, 9) != 0);
            end
        end
    endtask

    task automatic drain_levels(input int settle);
        item_bus.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_flat_mode(input logic [MODE_W-1:0] mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        flat_mode_shadow = mode;
    endtask

    // result side: check, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && level_bus.valid && level_bus.ready)
        begin
            if (expected_levels.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: style %0d level %0d last %0b",
                             level_bus.out_style_index, level_bus.level,
                             level_bus.last_style);
            end
            else
            begin
                sink_want = expected_levels.pop_front();
                if (level_bus.out_style_index !== sink_want.style
                    || level_bus.level !== sink_want.level
                    || level_bus.last_style !== sink_want.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: expected style %0d level %0d last %0b, got %0d %0d %0b",
                                 sink_want.style, sink_want.level, sink_want.last,
                                 level_bus.out_style_index, level_bus.level,
                                 level_bus.last_style);
                end
            end
            sink_wait = snk_idle_on ? $urandom_range(0, 11) : 0;
        end
        if (!rst_n)
            level_bus.ready <= 1'b0;
        else if (sink_wait > 0)
        begin
            sink_wait--;
            level_bus.ready <= 1'b0;
        end
        else
            level_bus.ready <= !hold_off;
    end

    // long hold on the result side
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        item_bus.valid       = 1'b0;
        item_bus.func        = FUNC_LOAD;
        item_bus.style_index = '0;
        item_bus.char_code   = '0;
        item_bus.time_tenths = '0;
        level_bus.ready      = 1'b0;
        for (int s = 0; s < NUM_STYLES; s++)
        begin
            style_len[s]  = 0;
            style_peak[s] = '0;
            style_avg[s]  = '0;
            for (int p = 0; p < PATTERN_CAPACITY; p++)
                style_chars[s][p] = '0;
        end
        ld_pos           = 0;
        ld_sum           = 0;
        ld_peak          = CHAR_BASE;
        ld_style         = 0;
        flat_mode_shadow = FLAT_ANIMATE;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_request(directed_rows[r].req, directed_rows[r].typed,
                         directed_rows[r].typed_style, directed_rows[r].typed_level);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_levels(SETTLE_CYCLES);
            write_flat_mode(phase_modes[ph]);
            src_idle_on = (ph % 3 != 1);
            snk_idle_on = (ph % 3 != 2);
            if (ph == 1)
            begin
                // stall the result side while requests keep coming
                send_tick();
                hold_go = 1'b1;
            end
            run_phase(PHASE_REQUESTS, ph == 3);
        end

        drain_levels(4 * SETTLE_CYCLES);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
